@@ hw/rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

   // Number of cells in the chain
   localparam int Capacity = 16;
   // Entry count holds 0 .. Capacity inclusive
   localparam int CntW = $clog2(Capacity + 1);
   localparam int IdW = 16;
   localparam int PrioW = 16;
   localparam int OccW = 5;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_POP    = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_NOP    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // One queue slot
   typedef struct packed {
      logic                    valid;
      logic [IdW-1:0]          id;
      logic signed [PrioW-1:0] prio;
   } entry_type;

   // Command broadcast to every cell; flags are already qualified by the transfer
   typedef struct packed {
      logic                    ins;
      logic                    pop;
      logic                    rem;
      logic [IdW-1:0]          key_id;
      logic signed [PrioW-1:0] key_prio;
   } cmd_type;

   // Status a cell reports to the chain and to the control
   typedef struct packed {
      logic ge;     // holds an entry that stays ahead of a new insert
      logic hit;    // an id match exists in this cell or any cell before it
      logic first;  // this cell holds the id match nearest the head
   } cell_stat_type;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_kind, req_task_id, req_task_priority
// rsp       out        rsp_valid/rsp_ready    rsp_status, rsp_out_id, rsp_out_priority,
//                                             rsp_occupancy
//
// One operation per cycle: every cell compares and shifts in the same cycle, and the
// result is registered, so a response appears in the cycle after the request transfer.
// One request per cycle while the receiver keeps up; the id match prefix sets the path.
// Reset clears the cell valid bits, the entry count and the response valid flag.
// A new request is taken while the response register is empty or being drained.

module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_kind,
   input  logic [IdW-1:0]          req_task_id,
   input  logic signed [PrioW-1:0] req_task_priority,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [IdW-1:0]          rsp_out_id,
   output logic signed [PrioW-1:0] rsp_out_priority,
   output logic [OccW-1:0]         rsp_occupancy
);

   entry_type     entries [Capacity];
   cell_stat_type stats   [Capacity];
   entry_type     empty_entry;
   cmd_type       cmd;
   logic          accept;
   logic          full;
   logic          empty;
   logic          found;
   kind_type      kind;

   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;
   logic [CntW+OccW-1:0]    count_ext;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              status_ff;
   status_type              status_in;
   logic [IdW-1:0]          out_id_ff;
   logic [IdW-1:0]          out_id_in;
   logic signed [PrioW-1:0] out_prio_ff;
   logic signed [PrioW-1:0] out_prio_in;
   logic [OccW-1:0]         occ_ff;
   logic [IdW-1:0]          sel_id;
   logic signed [PrioW-1:0] sel_prio;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign kind        = kind_type'(req_kind);
   assign full        = entries[Capacity-1].valid;
   assign empty       = !entries[0].valid;
   assign found       = stats[Capacity-1].hit;
   assign empty_entry = '0;

   // Chain of cells
   for (genvar g = 0; g < Capacity; g++) begin : g_cell
      entry_type l_entry;
      entry_type r_entry;
      logic      l_ge;
      logic      l_hit;

      if (g == 0) begin : g_head
         assign l_entry = empty_entry;
         assign l_ge    = 1'b1;
         assign l_hit   = 1'b0;
      end else begin : g_body
         assign l_entry = entries[g-1];
         assign l_ge    = stats[g-1].ge;
         assign l_hit   = stats[g-1].hit;
      end

      if (g == Capacity - 1) begin : g_tail
         assign r_entry = empty_entry;
      end else begin : g_mid
         assign r_entry = entries[g+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (l_entry),
         .left_ge     (l_ge),
         .left_hit    (l_hit),
         .right_entry (r_entry),
         .entry       (entries[g]),
         .stat        (stats[g])
      );
   end

   // Pick out the first id match
   always_comb begin
      sel_id   = '0;
      sel_prio = '0;
      for (int i = 0; i < Capacity; i++) begin
         if (stats[i].first) begin
            sel_id   = sel_id | entries[i].id;
            sel_prio = sel_prio | entries[i].prio;
         end
      end
   end

   // Decode the operation and form the response
   always_comb begin
      cmd.ins      = 1'b0;
      cmd.pop      = 1'b0;
      cmd.rem      = 1'b0;
      cmd.key_id   = req_task_id;
      cmd.key_prio = req_task_priority;
      status_in    = ST_OK;
      out_id_in    = '0;
      out_prio_in  = '0;
      case (kind)
         KIND_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins = accept;
            end
         end
         KIND_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cmd.pop     = accept;
               out_id_in   = entries[0].id;
               out_prio_in = entries[0].prio;
            end
         end
         KIND_REMOVE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (!found) begin
               status_in = ST_NOTFOUND;
            end else begin
               cmd.rem     = accept;
               out_id_in   = sel_id;
               out_prio_in = sel_prio;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.pop || cmd.rem) begin
         count_in = count_ff - CntW'(1);
      end
   end

   assign count_ext    = {{OccW{1'b0}}, count_in};
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response register, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         out_id_ff   <= out_id_in;
         out_prio_ff <= out_prio_in;
         occ_ff      <= count_ext[OccW-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_occupancy    = occ_ff;

`ifndef SYNTHESIS
   logic [Capacity-1:0] valid_vec;
   logic [Capacity-1:0] order_ok;

   always_comb begin
      for (int i = 0; i < Capacity; i++) begin
         valid_vec[i] = entries[i].valid;
         if (i == 0) begin
            order_ok[i] = 1'b1;
         end else begin
            order_ok[i] = !entries[i].valid ||
               (entries[i-1].valid && (entries[i-1].prio >= entries[i].prio));
         end
      end
   end

   // Valid cells match the entry count
   a_count_valid : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("cell valid bits disagree with entry count");

   // Held entries stay sorted and packed towards the head
   a_sorted : assert property (@(posedge clock) disable iff (reset)
      &order_ok)
      else $error("queue order broken");

   // A full response is only given when every cell is taken
   a_full_status : assert property (@(posedge clock) disable iff (reset)
      accept && (status_in == ST_FULL) |=> count_ff == CntW'(Capacity))
      else $error("full reported with free cells");

   // A stalled response blocks new requests
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");
`endif

endmodule

@@ hw/rtl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  entry_type     left_entry,
   input  logic          left_ge,
   input  logic          left_hit,
   input  entry_type     right_entry,
   output entry_type     entry,
   output cell_stat_type stat
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;

   // Local compares
   assign match     = entry_ff.valid && (entry_ff.id == cmd.key_id);
   assign stat.ge   = entry_ff.valid && (entry_ff.prio >= cmd.key_prio);
   assign stat.hit  = left_hit || match;
   assign stat.first = match && !left_hit;
   assign entry     = entry_ff;

   // Next slot contents: keep, take new, shift from left or shift from right
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!stat.ge) begin
            if (left_ge) begin
               entry_in.valid = 1'b1;
               entry_in.id    = cmd.key_id;
               entry_in.prio  = cmd.key_prio;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end else if (cmd.rem) begin
         if (stat.hit) begin
            entry_in = right_entry;
         end
      end
   end

   // Only the valid bit is cleared by reset; id and priority need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id   <= entry_in.id;
      entry_ff.prio <= entry_in.prio;
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import spq_pkg::*;

   localparam int RandomItems = 1900;
   localparam int CycleLimit  = 200000;

   // Idle profile: slow receiver, then slow sender, then full rate
   typedef enum int {
      PACE_SLOW_RSP,
      PACE_SLOW_REQ,
      PACE_FULL
   } pace_type;

   // Shape of a random burst
   typedef enum int {
      BURST_FILL,
      BURST_DRAIN,
      BURST_MIXED
   } burst_type;

   typedef struct {
      kind_type                kind;
      logic [IdW-1:0]          id;
      logic signed [PrioW-1:0] prio;
      pace_type                pace;
   } request_type;

   typedef struct {
      status_type              status;
      logic [IdW-1:0]          id;
      logic signed [PrioW-1:0] prio;
      logic [OccW-1:0]         occ;
   } outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_kind = KIND_NOP;
   logic [IdW-1:0]          req_task_id = '0;
   logic signed [PrioW-1:0] req_task_priority = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [IdW-1:0]          rsp_out_id;
   logic signed [PrioW-1:0] rsp_out_priority;
   logic [OccW-1:0]         rsp_occupancy;

   request_type req_backlog[$];
   outcome_type due_outcomes[$];
   pace_type    cur_pace = PACE_SLOW_RSP;
   int          errors = 0;
   int          cycle_count = 0;

   // Shadow copy of the sorted queue
   logic [IdW-1:0]          shadow_ids[Capacity];
   logic signed [PrioW-1:0] shadow_prios[Capacity];
   int                      shadow_count = 0;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one operation to the shadow queue and return its response
   function automatic outcome_type apply_queue_op(kind_type kind, logic [IdW-1:0] id,
                                                  logic signed [PrioW-1:0] prio);
      outcome_type r;
      int pos;
      int i;
      r.status = ST_OK;
      r.id = '0;
      r.prio = '0;
      pos = 0;
      case (kind)
         KIND_INSERT: begin
            if (shadow_count >= Capacity) begin
               r.status = ST_FULL;
            end else begin
               // equal priorities keep arrival order
               while (pos < shadow_count && shadow_prios[pos] >= prio) pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_ids[i] = shadow_ids[i-1];
                  shadow_prios[i] = shadow_prios[i-1];
               end
               shadow_ids[pos] = id;
               shadow_prios[pos] = prio;
               shadow_count++;
            end
         end
         KIND_POP, KIND_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // pop takes the head; remove takes the match nearest the head
               if (kind == KIND_REMOVE) begin
                  while (pos < shadow_count && shadow_ids[pos] != id) pos++;
               end
               if (pos == shadow_count) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  r.id = shadow_ids[pos];
                  r.prio = shadow_prios[pos];
                  for (i = pos; i < shadow_count - 1; i++) begin
                     shadow_ids[i] = shadow_ids[i+1];
                     shadow_prios[i] = shadow_prios[i+1];
                  end
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      r.occ = shadow_count[OccW-1:0];
      return r;
   endfunction

   function automatic int idle_pct(pace_type pace, bit receiver);
      case (pace)
         PACE_SLOW_RSP: return receiver ? 61 : 34;
         PACE_SLOW_REQ: return receiver ? 34 : 61;
         default:       return 0;
      endcase
   endfunction

   function automatic void push_req(kind_type kind, logic [IdW-1:0] id,
                                    logic signed [PrioW-1:0] prio);
      request_type t;
      t.kind = kind;
      t.id = id;
      t.prio = prio;
      t.pace = PACE_FULL;
      req_backlog.push_back(t);
   endfunction

   task automatic check_field(string name, int exp, int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
         errors++;
      end
   endtask

   // Request driver: a transfer is recorded in the shadow queue as it happens
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            due_outcomes.push_back(apply_queue_op(kind_type'(req_kind), req_task_id,
                                                  req_task_priority));
            void'(req_backlog.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the item until it transfers
         end else if (req_backlog.size() != 0 &&
                      $urandom_range(99, 0) >= idle_pct(req_backlog[0].pace, 1'b0)) begin
            nxt = req_backlog[0];
            req_valid <= 1'b1;
            req_kind <= nxt.kind;
            req_task_id <= nxt.id;
            req_task_priority <= nxt.prio;
            cur_pace <= nxt.pace;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      outcome_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_outcomes.size() == 0) begin
               $display("%0t: response with none expected, status %0d id %0d prio %0d",
                        $time, rsp_status, rsp_out_id, rsp_out_priority);
               errors++;
            end else begin
               exp = due_outcomes.pop_front();
               check_field("status", exp.status, rsp_status);
               check_field("out_id", exp.id, rsp_out_id);
               check_field("out_priority", exp.prio, rsp_out_priority);
               check_field("occupancy", exp.occ, rsp_occupancy);
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= idle_pct(cur_pace, 1'b1));
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t: timeout with %0d items and %0d responses outstanding",
                  $time, req_backlog.size(), due_outcomes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int n;
      int b;
      int burst_len;
      int roll;
      int total;
      burst_type burst;
      kind_type kind;
      logic [IdW-1:0] id;
      logic signed [PrioW-1:0] prio;

      // Directed: empty cases, extremes, ties, duplicate ids, full queue
      push_req(KIND_POP, 16'h0000, 16'sh0000);
      push_req(KIND_REMOVE, 16'hFFFF, 16'sh7FFF);
      push_req(KIND_NOP, 16'h0000, 16'sh0000);
      push_req(KIND_INSERT, 16'h0000, 16'sh8000);
      push_req(KIND_INSERT, 16'hFFFF, 16'sh7FFF);
      push_req(KIND_INSERT, 16'h0005, 16'sh0000);
      push_req(KIND_INSERT, 16'h0006, 16'sh0000);
      push_req(KIND_INSERT, 16'h0005, 16'sh0064);
      push_req(KIND_REMOVE, 16'h0005, 16'sh0000);
      push_req(KIND_REMOVE, 16'h1234, 16'sh0000);
      push_req(KIND_NOP, 16'hFFFF, 16'sh8000);
      for (n = 0; n < 12; n++) begin
         push_req(KIND_INSERT, IdW'(16'h0100 + n), PrioW'((n % 3) - 1));
      end
      push_req(KIND_INSERT, 16'hAAAA, 16'sh7FFF);
      push_req(KIND_POP, 16'h5555, 16'sh0000);

      // Random bursts, each picked at random to fill, drain or mix the queue
      n = 0;
      while (n < RandomItems) begin
         burst_len = $urandom_range(40, 8);
         burst = burst_type'($urandom_range(2, 0));
         for (b = 0; b < burst_len && n < RandomItems; b++) begin
            roll = $urandom_range(99, 0);
            case (burst)
               BURST_FILL:  kind = roll < 70 ? KIND_INSERT : roll < 80 ? KIND_POP :
                                   roll < 96 ? KIND_REMOVE : KIND_NOP;
               BURST_DRAIN: kind = roll < 20 ? KIND_INSERT : roll < 60 ? KIND_POP :
                                   roll < 96 ? KIND_REMOVE : KIND_NOP;
               default:     kind = roll < 45 ? KIND_INSERT : roll < 70 ? KIND_POP :
                                   roll < 96 ? KIND_REMOVE : KIND_NOP;
            endcase
            // a small id pool makes removes hit and duplicates common
            id = ($urandom_range(99, 0) < 70) ? IdW'($urandom_range(15, 0)) :
                                                IdW'($urandom);
            roll = $urandom_range(99, 0);
            if (roll < 40) begin
               prio = PrioW'(int'($urandom_range(6, 0)) - 3);
            end else if (roll < 80) begin
               prio = PrioW'($urandom);
            end else begin
               case ($urandom_range(3, 0))
                  0:       prio = 16'sh8000;
                  1:       prio = 16'sh7FFF;
                  2:       prio = -16'sd1;
                  default: prio = 16'sh0000;
               endcase
            end
            push_req(kind, id, prio);
            n++;
         end
      end

      // Split the run into the three idle profiles
      total = req_backlog.size();
      for (n = 0; n < total; n++) req_backlog[n].pace = pace_type'((n * 3) / total);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || due_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
